// ===== design/sfc_pkg.sv =====
// Shared types and helpers for the sparse Cholesky factor block.
// No dependencies; imported by sfc_arith and sparse_cholesky_factor.
package sfc_pkg;

  // operation codes of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } arith_req_t;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int SIZE_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // packed lower-triangle position r*(r+1)/2 + c
  function automatic logic [7:0] tri_pos(input logic [3:0] r, input logic [3:0] c);
    logic [7:0] rr;
    logic [7:0] prod;
    rr   = {4'b0, r};
    prod = 8'(rr * (rr + 8'd1));
    return (prod >> 1) + {4'b0, c};
  endfunction

endpackage

// ===== design/sfc_arith.sv =====
// Shared arithmetic unit: rounded Q-format multiply, bit-serial square root
// and bit-serial rounded divide. Depends on sfc_pkg.
module sfc_arith #(
  parameter int FRAC_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sfc_pkg::arith_req_t        req,
  input  logic signed [31:0]         a,
  input  logic signed [31:0]         b,
  output logic                       done,
  output logic signed [63:0]         res
);
  import sfc_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic              busy;
  logic              fin;
  op_t               op_q;
  logic [6:0]        cnt;
  logic signed [63:0] acc;
  logic [63:0]       v;
  logic [63:0]       r;
  logic [63:0]       bm;
  logic [31:0]       den;
  logic              neg;
  logic [31:0]       mag;
  logic [63:0]       sq_t;
  logic [32:0]       remsh;
  logic              ge;
  logic signed [63:0] mul_res;
  logic [31:0]       div_res;

  assign mag   = a[31] ? 32'(~a + 32'sd1) : 32'(a);
  assign sq_t  = r + bm;
  assign remsh = {r[31:0], v[63]};
  assign ge    = remsh >= {1'b0, den};

  // sequencing and iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_q <= req.op;
        case (req.op)
          OP_MUL: begin
            acc <= 64'(a) * 64'(b);
            cnt <= 7'd1;
          end
          OP_SQRT: begin
            v   <= {32'b0, a} << FRAC_BITS;
            r   <= '0;
            bm  <= 64'h4000_0000_0000_0000;
            cnt <= 7'd32;
          end
          OP_DIV: begin
            neg <= a[31];
            v   <= ({32'b0, mag} << FRAC_BITS) + {33'b0, b[31:1]};
            r   <= '0;
            den <= b;
            cnt <= 7'd64;
          end
          default: cnt <= 7'd1;
        endcase
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
        case (op_q)
          OP_SQRT: begin
            if (v >= sq_t) begin
              v <= v - sq_t;
              r <= (r >> 1) + bm;
            end else begin
              r <= r >> 1;
            end
            bm <= bm >> 2;
          end
          OP_DIV: begin
            v <= {v[62:0], ge};
            r <= ge ? 64'(remsh - {1'b0, den}) : 64'(remsh);
          end
          default: ;
        endcase
      end
    end
  end

  // result formatting
  assign mul_res = (acc + HALF) >>> FRAC_BITS;

  always_comb begin
    if (!neg) begin
      div_res = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    end else begin
      div_res = (v > 64'h8000_0000) ? 32'h8000_0000 : 32'(-v[31:0]);
    end
  end

  always_comb begin
    case (op_q)
      OP_MUL:  res = mul_res;
      OP_SQRT: res = (v > r) ? 64'(r + 64'd1) : 64'(r);
      OP_DIV:  res = {{32{div_res[31]}}, div_res};
      default: res = '0;
    endcase
  end

  assign done = fin;

endmodule

// ===== design/sparse_cholesky_factor.sv =====
// Top level of the sparse left-looking Cholesky factor: entry store,
// factor store, column sequencer and output register. Uses sfc_pkg, sfc_arith.
//
//  channel  | dir | beat contents
//  s_*      | in  | tdata row,col,value; tlast marks the final entry
//  m_*      | out | tdata out_row,out_col,out_value; tuser status; tlast out_last
//  cfg_*    | in  | matrix_size, written on cfg_we
//
// Loading takes one cycle per entry. Factoring an order-n matrix runs on the
// shared arithmetic unit: entry reads, update multiply-subtracts, square roots
// and divides, then the factor entries are emitted. s_tready is high only while
// loading. Reset is synchronous; no clearing pass is needed. A stalled m_tready
// holds the emit sequence; the last result may wait while loading resumes.
module sparse_cholesky_factor #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6], zero[39:38]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6], zero
  output logic        m_tuser,   // status
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata  // matrix_size
);
  import sfc_pkg::*;

  localparam int TRI = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int TW  = (TRI > 1) ? $clog2(TRI) : 1;
  localparam int CW  = $clog2(MAX_ORDER + 1);
  localparam int IW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [15:0] {
    S_LOAD  = 16'h0001,
    S_COL   = 16'h0002,
    S_ECHK  = 16'h0004,
    S_EDAT  = 16'h0008,
    S_KCHK  = 16'h0010,
    S_KM    = 16'h0020,
    S_ICHK  = 16'h0040,
    S_IMUL  = 16'h0080,
    S_IWAIT = 16'h0100,
    S_PIV   = 16'h0200,
    S_SQW   = 16'h0400,
    S_DCHK  = 16'h0800,
    S_DW    = 16'h1000,
    S_ERR   = 16'h2000,
    S_OCHK  = 16'h4000,
    S_ODAT  = 16'h8000
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   matrix_size;
  logic [CW-1:0]       n, i, j, k;
  logic [TRI-1:0]      pres;
  logic [TRI-1:0]      lpb;
  logic [TW-1:0]       last_pos;
  logic signed [31:0]  wv [MAX_ORDER];
  logic [MAX_ORDER-1:0] wp;
  logic signed [31:0]  m;
  logic signed [31:0]  root;

  logic signed [31:0]  emem [TRI];
  logic signed [31:0]  lmem [TRI];
  logic signed [31:0]  erd, lrd;

  logic [IDX_W-1:0]    in_row, in_col;
  logic signed [31:0]  in_value;
  logic                store_ok;
  logic [TW-1:0]       t_in, t_ij, t_jk, t_ik, lra;
  logic [IW-1:0]       wsel;
  logic signed [31:0]  wrd;
  logic                wpr;
  logic                out_free;
  logic                emit;
  logic                l_we;
  logic signed [31:0]  l_wd;

  arith_req_t          areq;
  logic signed [31:0]  aa, ab;
  logic                adone;
  logic signed [63:0]  ares;
  logic signed [65:0]  diff;
  logic signed [31:0]  upd;
  logic [CW-1:0]       n_sel;

  // input unpacking
  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[5:3];
  assign in_value = s_tdata[37:6];
  assign store_ok = (in_row >= in_col) && (32'(in_row) < MAX_ORDER);
  assign s_tready = (state == S_LOAD);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = out_free && ((state == S_ERR) || (state == S_ODAT));

  // triangle positions
  assign t_in = TW'(tri_pos({1'b0, in_row}, {1'b0, in_col}));
  assign t_ij = TW'(tri_pos(4'(i), 4'(j)));
  assign t_jk = TW'(tri_pos(4'(j), 4'(k)));
  assign t_ik = TW'(tri_pos(4'(i), 4'(k)));

  always_comb begin
    case (state)
      S_KCHK:  lra = t_jk;
      S_ICHK:  lra = t_ik;
      default: lra = t_ij;
    endcase
  end

  // working column read port
  assign wsel = (state == S_PIV) ? j[IW-1:0] : i[IW-1:0];
  assign wrd  = wv[wsel];
  assign wpr  = wp[wsel];

  // effective order
  assign n_sel = (matrix_size == '0) ? CW'(1) :
                 (32'(matrix_size) > MAX_ORDER) ? CW'(MAX_ORDER) : CW'(matrix_size);

  // update subtract with saturation
  assign diff = {{34{wrd[31]}}, wrd} - {{2{ares[63]}}, ares};
  assign upd  = (diff > 66'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                (diff < -66'sh8000_0000) ? 32'sh8000_0000 : diff[31:0];

  // arithmetic requests
  always_comb begin
    areq.start = 1'b0;
    areq.op    = OP_MUL;
    aa         = wrd;
    ab         = root;
    case (state)
      S_IMUL: begin
        areq.start = 1'b1;
        areq.op    = OP_MUL;
        aa         = m;
        ab         = lrd;
      end
      S_PIV: begin
        areq.start = wpr && (wrd > 32'sd0);
        areq.op    = OP_SQRT;
      end
      S_DCHK: begin
        areq.start = (i != n) && wpr && (i != j);
        areq.op    = OP_DIV;
      end
      default: ;
    endcase
  end

  sfc_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (areq),
    .a    (aa),
    .b    (ab),
    .done (adone),
    .res  (ares)
  );

  // factor store write port
  always_comb begin
    l_we = 1'b0;
    l_wd = ares[31:0];
    if (state == S_DCHK && i != n && wpr && i == j) begin
      l_we = 1'b1;
      l_wd = root;
    end else if (state == S_DW && adone) begin
      l_we = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state == S_LOAD && s_tvalid && store_ok) emem[t_in] <= in_value;
    erd <= emem[t_ij];
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[t_ij] <= l_wd;
    lrd <= lmem[lra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      matrix_size <= SIZE_RESET;
      pres        <= '0;
      lpb         <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) matrix_size <= cfg_wdata;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (l_we) begin
        lpb[t_ij] <= 1'b1;
        last_pos  <= t_ij;
      end
      case (state)
        S_LOAD: begin
          if (s_tvalid) begin
            if (store_ok) pres[t_in] <= 1'b1;
            if (s_tlast) begin
              n     <= n_sel;
              j     <= '0;
              lpb   <= '0;
              state <= S_COL;
            end
          end
        end
        S_COL: begin
          if (j == n) begin
            i     <= '0;
            j     <= '0;
            state <= S_OCHK;
          end else begin
            i     <= j;
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (i == n) begin
            k     <= '0;
            state <= S_KCHK;
          end else begin
            state <= S_EDAT;
          end
        end
        S_EDAT: begin
          wp[i[IW-1:0]] <= pres[t_ij];
          wv[i[IW-1:0]] <= pres[t_ij] ? erd : 32'sd0;
          i     <= i + CW'(1);
          state <= S_ECHK;
        end
        S_KCHK: begin
          if (k == j) begin
            state <= S_PIV;
          end else if (lpb[t_jk]) begin
            state <= S_KM;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_KM: begin
          m <= lrd;
          i <= j;
          if (lrd == 32'sd0) begin
            k     <= k + CW'(1);
            state <= S_KCHK;
          end else begin
            state <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (i == n) begin
            k     <= k + CW'(1);
            state <= S_KCHK;
          end else if (lpb[t_ik]) begin
            state <= S_IMUL;
          end else begin
            i <= i + CW'(1);
          end
        end
        S_IMUL: state <= S_IWAIT;
        S_IWAIT: begin
          if (adone) begin
            wv[i[IW-1:0]] <= upd;
            wp[i[IW-1:0]] <= 1'b1;
            i     <= i + CW'(1);
            state <= S_ICHK;
          end
        end
        S_PIV: state <= areq.start ? S_SQW : S_ERR;
        S_SQW: begin
          if (adone) begin
            root  <= ares[31:0];
            i     <= j;
            state <= S_DCHK;
          end
        end
        S_DCHK: begin
          if (i == n) begin
            j     <= j + CW'(1);
            state <= S_COL;
          end else if (areq.start) begin
            state <= S_DW;
          end else begin
            i <= i + CW'(1);
          end
        end
        S_DW: begin
          if (adone) begin
            i     <= i + CW'(1);
            state <= S_DCHK;
          end
        end
        S_ERR: begin
          if (out_free) begin
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            m_tdata  <= {2'b0, 32'b0, IDX_W'(j), {IDX_W{1'b0}}};
            pres     <= '0;
            state    <= S_LOAD;
          end
        end
        S_OCHK: begin
          if (j == n) begin
            pres  <= '0;
            state <= S_LOAD;
          end else if (i == n) begin
            j <= j + CW'(1);
            i <= j + CW'(1);
          end else if (lpb[t_ij]) begin
            state <= S_ODAT;
          end else begin
            i <= i + CW'(1);
          end
        end
        S_ODAT: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            m_tlast  <= (t_ij == last_pos);
            m_tdata  <= {2'b0, lrd, IDX_W'(j), IDX_W'(i)};
            i        <= i + CW'(1);
            state    <= S_OCHK;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== design/sfc_checker.sv =====
// Port-level checks for sparse_cholesky_factor, attached by bind.
// Sees only the top-level ports; no package needed.
module sfc_port_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // an error beat is the final one and carries zero row and value
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata[2:0] == 3'd0 && m_tdata[37:6] == 32'd0)
    else $error("malformed error beat");

  // the final entry starts factoring, so input closes
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still open after final entry");

endmodule

bind sparse_cholesky_factor sfc_port_assertions u_sfc_port_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== dv/sfc_checker.sv =====
// Checker for the sparse Cholesky factor: watches the entry and factor channels,
// predicts the factor entries and compares them. Depends on the block's port widths only.
module sfc_checker #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam int TRI = MAX_ORDER * (MAX_ORDER + 1) / 2;

  typedef struct packed {
    logic        status;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } factor_beat_t;

  logic signed [31:0] entry_val [TRI];
  logic               entry_here [TRI];
  logic [3:0]         order_reg;
  factor_beat_t       factor_q [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rounded Q product, round half up
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // rounded square root of pivot scaled by 2^FRAC_BITS
  function automatic longint qsqrt(input longint p);
    logic [63:0] v, r, b;
    v = 64'(p) << FRAC_BITS;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r = r + 1;
    return longint'(r);
  endfunction

  function automatic longint qdiv(input longint num, input longint den);
    logic        neg;
    logic [63:0] mag, q;
    neg = num < 0;
    mag = neg ? 64'(-num) : 64'(num);
    q = ((mag << FRAC_BITS) + 64'(den) / 2) / 64'(den);
    if (!neg) return (q > 64'h7fffffff) ? 64'sd2147483647 : longint'(q);
    if (q > 64'h80000000) return -64'sd2147483648;
    return -longint'(q);
  endfunction

  function automatic int tri_idx(input int r, input int c);
    return r * (r + 1) / 2 + c;
  endfunction

  // left-looking factorization of the stored lower triangle
  task automatic factor_matrix();
    int           n, cnt, t;
    longint       w [MAX_ORDER];
    bit           wp [MAX_ORDER];
    longint       lv [MAX_ORDER][MAX_ORDER];
    bit           lp [MAX_ORDER][MAX_ORDER];
    longint       root, v, m;
    factor_beat_t fb;
    n = order_reg;
    if (n == 0) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    cnt = 0;
    for (int i = 0; i < MAX_ORDER; i++)
      for (int k = 0; k < MAX_ORDER; k++) begin
        lv[i][k] = 0;
        lp[i][k] = 0;
      end
    for (int j = 0; j < n; j++) begin
      for (int i = j; i < n; i++) begin
        t = tri_idx(i, j);
        wp[i] = entry_here[t];
        w[i] = wp[i] ? longint'(entry_val[t]) : 0;
      end
      for (int k = 0; k < j; k++) begin
        if (!lp[j][k] || lv[j][k] == 0) continue;
        m = lv[j][k];
        for (int i = j; i < n; i++) begin
          if (!lp[i][k]) continue;
          wp[i] = 1;
          w[i] = clamp32(w[i] - qmul(m, lv[i][k]));
        end
      end
      // non-positive or missing pivot: single error beat replaces the factor
      if (!wp[j] || w[j] <= 0) begin
        repeat (cnt) void'(factor_q.pop_back());
        fb = '{status: 1'b1, row: 3'd0, col: 3'(j), value: 32'd0, last: 1'b1};
        factor_q.push_back(fb);
        for (int i = 0; i < TRI; i++) entry_here[i] = 0;
        return;
      end
      root = qsqrt(w[j]);
      for (int i = j; i < n; i++) begin
        if (!wp[i]) continue;
        v = (i == j) ? clamp32(root) : qdiv(w[i], root);
        lp[i][j] = 1;
        lv[i][j] = longint'(signed'(32'(v)));
        fb = '{status: 1'b0, row: 3'(i), col: 3'(j), value: 32'(v), last: 1'b0};
        factor_q.push_back(fb);
        cnt++;
      end
    end
    factor_q[factor_q.size() - 1].last = 1'b1;
    for (int i = 0; i < TRI; i++) entry_here[i] = 0;
  endtask

  always @(posedge clk) begin
    factor_beat_t got, exp_b;
    int           r, c;
    if (rst) begin
      order_reg <= 4'd8;
      for (int i = 0; i < TRI; i++) entry_here[i] = 0;
      factor_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) order_reg <= cfg_wdata;
      // entry beat
      if (s_tvalid && s_tready) begin
        r = s_tdata[2:0];
        c = s_tdata[5:3];
        if (r >= c && r < MAX_ORDER) begin
          entry_val[tri_idx(r, c)] = s_tdata[37:6];
          entry_here[tri_idx(r, c)] = 1;
        end
        if (s_tlast) factor_matrix();
      end
      // factor beat
      if (m_tvalid && m_tready) begin
        got = '{status: m_tuser, row: m_tdata[2:0], col: m_tdata[5:3],
                value: m_tdata[37:6], last: m_tlast};
        if (factor_q.size() == 0) begin
          $error("unexpected factor beat row %0d col %0d", got.row, got.col);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = factor_q.pop_front();
          if (got != exp_b) begin
            if (got.status != exp_b.status)
              $error("status: expected %0d, got %0d", exp_b.status, got.status);
            if (got.row != exp_b.row)
              $error("out_row: expected %0d, got %0d", exp_b.row, got.row);
            if (got.col != exp_b.col)
              $error("out_col: expected %0d, got %0d", exp_b.col, got.col);
            if (got.value != exp_b.value)
              $error("out_value: expected %h, got %h", exp_b.value, got.value);
            if (got.last != exp_b.last)
              $error("out_last: expected %0d, got %0d", exp_b.last, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= factor_q.size();
    end
  end

endmodule

// ===== dv/tb_sparse_cholesky_factor.sv =====
// Testbench top for sparse_cholesky_factor: drives entry matrices and size
// writes, stalls the result side, and reports the verdict from sfc_checker.
module tb_sparse_cholesky_factor;

  localparam int  ONE = 1 << 20;
  localparam int  LIMIT = 3000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [3:0]  cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          gap_left = 0;
  bit          stall_on = 1;

  always #2 clk = ~clk;

  sparse_cholesky_factor dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast, .cfg_we, .cfg_wdata
  );

  sfc_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast, .cfg_we, .cfg_wdata,
    .fail_count, .pending
  );

  // receiver stall pattern: phases of free flow and phases of random stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    m_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one entry beat, with burst/gap idling before it; valid stays up between
  // back-to-back beats and drops only for a gap or in drain
  task automatic send_entry(input int r, input int c, input logic [31:0] v, input bit lst);
    if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 6);
    if (gap_left > 0) s_tvalid <= 0;
    while (gap_left > 0) begin
      @(negedge clk);
      gap_left--;
    end
    s_tvalid <= 1;
    s_tdata <= {2'b00, v, 3'(c), 3'(r)};
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4000) @(negedge clk);
  endtask

  task automatic write_size(input logic [3:0] sz);
    drain();
    cfg_we <= 1;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // random diagonally dominant matrix of order n, random sparsity
  task automatic send_spd(input int n);
    logic [31:0] v;
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= r; c++) begin
        if (r == c) v = ONE * n + $urandom_range(0, 4 * ONE);
        else if ($urandom_range(0, 2) == 0) continue;
        else v = $urandom_range(0, 2 * ONE) - ONE;
        send_entry(r, c, v, (r == n - 1) && (c == r));
      end
  endtask

  // arbitrary entries, including above-diagonal and extreme values
  task automatic send_noise(input int k);
    for (int i = 0; i < k; i++)
      send_entry($urandom_range(0, 7), $urandom_range(0, 7), $urandom, i == k - 1);
  endtask

  initial begin
    int n;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: 1x1, empty-like pivot failures, extremes, fill-in, ignored entries
    write_size(4'd1);
    send_entry(0, 0, 32'h7fffffff, 1);
    send_entry(0, 0, 32'h80000000, 1);
    send_entry(0, 0, 32'h00000000, 1);
    send_entry(3, 5, ONE, 0);
    send_entry(0, 0, ONE, 0);
    send_entry(0, 0, 4 * ONE, 1);
    write_size(4'd0);
    send_entry(0, 0, 9 * ONE, 1);
    write_size(4'd15);
    send_entry(1, 0, ONE, 0);
    send_entry(1, 1, 0, 1);
    write_size(4'd3);
    send_entry(0, 0, 4 * ONE, 0);
    send_entry(2, 0, 2 * ONE, 0);
    send_entry(1, 1, ONE, 0);
    send_entry(2, 1, 0, 0);
    send_entry(7, 7, ONE, 0);
    send_entry(2, 2, 5 * ONE, 1);
    write_size(4'd8);
    send_entry(7, 6, 32'hffffffff, 0);
    send_entry(5, 2, 32'h7fffffff, 1);
    write_size(4'd2);
    send_entry(0, 0, 32'h00000001, 0);
    send_entry(1, 0, 32'h7fffffff, 0);
    send_entry(1, 1, 32'h7fffffff, 1);

    // random: mostly well-formed matrices, some noise
    for (int blk = 0; blk < 16; blk++) begin
      n = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 5);
      if (blk % 6 == 0) write_size($urandom_range(0, 1) ? 4'(n) : 4'($urandom_range(0, 15)));
      else write_size(4'(n));
      for (int t = 0; t < 3; t++) begin
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 6));
        else send_spd(n);
      end
    end

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
